FILE: rtl/qte_pkg.sv
// shared types, constants and helpers for the quaternion to euler angle unit
// no dependencies
package qte_pkg;

	localparam int TAB_LEN  = 24;
	localparam int ANG_W    = 32;
	localparam int VEC_W    = 36;
	localparam int THR_W    = 14;
	localparam int HEAD_W   = 17;
	localparam int ATT_W    = 15;
	localparam int BANK_W   = 16;
	localparam int POLE_W   = 2;

	localparam logic [THR_W-1:0] THR_RESET = 14'd8176;
	localparam logic signed [ANG_W-1:0] DEG90 = 32'sd5898240;
	localparam logic signed [ATT_W-1:0] ATT_N90 = -15'sd11520;
	localparam logic signed [ATT_W-1:0] ATT_P90 = 15'sd11520;

	typedef enum logic [POLE_W-1:0] {
		POLE_NONE  = 2'd0,
		POLE_NORTH = 2'd1,
		POLE_SOUTH = 2'd2
	} pole_t;

	// atan(2^-i) in 2^-16 degree units, rounded
	function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] i);
		logic signed [ANG_W-1:0] r;
		begin
			case (i)
				5'd0: r = 32'sd2949120;
				5'd1: r = 32'sd1740967;
				5'd2: r = 32'sd919879;
				5'd3: r = 32'sd466945;
				5'd4: r = 32'sd234379;
				5'd5: r = 32'sd117304;
				5'd6: r = 32'sd58666;
				5'd7: r = 32'sd29335;
				5'd8: r = 32'sd14668;
				5'd9: r = 32'sd7334;
				5'd10: r = 32'sd3667;
				5'd11: r = 32'sd1833;
				5'd12: r = 32'sd917;
				5'd13: r = 32'sd458;
				5'd14: r = 32'sd229;
				5'd15: r = 32'sd115;
				5'd16: r = 32'sd57;
				5'd17: r = 32'sd29;
				5'd18: r = 32'sd14;
				5'd19: r = 32'sd7;
				5'd20: r = 32'sd4;
				5'd21: r = 32'sd2;
				5'd22: r = 32'sd1;
				default: r = 32'sd0;
			endcase
			return r;
		end
	endfunction

	// per-stage sideband carried down the cell chain
	typedef struct packed {
		logic                        pole_n;
		logic                        pole_s;
		logic signed [ANG_W-1:0]     acc_h;
		logic signed [ANG_W-1:0]     acc_a;
		logic signed [ANG_W-1:0]     acc_b;
	} side_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
	} vec_t;

	typedef struct packed {
		logic signed [HEAD_W-1:0] heading_deg;
		logic signed [ATT_W-1:0]  attitude_deg;
		logic signed [BANK_W-1:0] bank_deg;
		logic [POLE_W-1:0]        pole_case;
	} res_t;

endpackage

FILE: rtl/qte_if.sv
// valid/ready channel interface with generic payload
// depends on nothing
interface qte_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/qte_front.sv
// front end: products, pole test, vector setup and pre-rotation (two stages)
// depends on qte_pkg
module qte_front #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic signed [COMPONENT_BITS-1:0]  w_i,
	input  logic signed [COMPONENT_BITS-1:0]  x_i,
	input  logic signed [COMPONENT_BITS-1:0]  y_i,
	input  logic signed [COMPONENT_BITS-1:0]  z_i,
	input  logic [qte_pkg::THR_W-1:0]         thr,
	output logic                              out_vld,
	output qte_pkg::vec_t                     vh,
	output qte_pkg::vec_t                     va,
	output qte_pkg::vec_t                     vb,
	output logic                              pole_n,
	output logic                              pole_s,
	output logic signed [qte_pkg::ANG_W-1:0]  zh,
	output logic signed [qte_pkg::ANG_W-1:0]  za,
	output logic signed [qte_pkg::ANG_W-1:0]  zb,
	output logic signed [qte_pkg::VEC_W-1:0]  s_sq
);
	import qte_pkg::*;

	localparam int Q = 16;

	function automatic logic signed [Q-1:0] to_q14(input logic signed [COMPONENT_BITS-1:0] v);
		logic signed [Q-1:0] r;
		begin
			if (COMPONENT_BITS >= Q) r = Q'(v >>> (COMPONENT_BITS - Q));
			else r = Q'(v) <<< (Q - COMPONENT_BITS);
			return r;
		end
	endfunction

	logic signed [Q-1:0] w, x, y, z;
	assign w = to_q14(w_i);
	assign x = to_q14(x_i);
	assign y = to_q14(y_i);
	assign z = to_q14(z_i);

	// stage 1: all pairwise products
	logic                    vld_s1;
	logic signed [31:0] xy_s1, zw_s1, yw_s1, xz_s1, yy_s1, zz_s1, xw_s1, yz_s1, xx_s1;
	logic signed [Q-1:0] x_s1, w_s1;
	logic [THR_W-1:0] thr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			xy_s1 <= x * y; zw_s1 <= z * w; yw_s1 <= y * w; xz_s1 <= x * z;
			yy_s1 <= y * y; zz_s1 <= z * z; xw_s1 <= x * w; yz_s1 <= y * z;
			xx_s1 <= x * x; x_s1 <= x; w_s1 <= w; thr_s1 <= thr;
		end
	end

	// stage 2: sums, pole test, vectors, clamp, pre-rotation
	localparam logic signed [VEC_W-1:0] ONE = VEC_W'(64'sd1 <<< 28);
	logic signed [VEC_W-1:0] test, thv, s, hy, hx, by, bx, px, py;
	logic pn, ps;
	always_comb begin
		test = VEC_W'(xy_s1) + VEC_W'(zw_s1);
		thv  = VEC_W'({thr_s1, 14'd0});
		pn   = test > thv;
		ps   = test < -thv;
		s    = test <<< 1;
		if (s > ONE) s = ONE;
		if (s < -ONE) s = -ONE;
		hy = (VEC_W'(yw_s1) - VEC_W'(xz_s1)) <<< 1;
		hx = ONE - ((VEC_W'(yy_s1) + VEC_W'(zz_s1)) <<< 1);
		by = (VEC_W'(xw_s1) - VEC_W'(yz_s1)) <<< 1;
		bx = ONE - ((VEC_W'(xx_s1) + VEC_W'(zz_s1)) <<< 1);
		px = VEC_W'(w_s1) <<< 14;
		py = VEC_W'(x_s1) <<< 14;
	end

	function automatic logic [2*VEC_W+ANG_W-1:0] prerot(input logic signed [VEC_W-1:0] yy,
		input logic signed [VEC_W-1:0] xx);
		logic signed [VEC_W-1:0] ox, oy;
		logic signed [ANG_W-1:0] oz;
		begin
			ox = xx; oy = yy; oz = '0;
			if (xx < 0) begin
				if (yy >= 0) begin
					ox = yy; oy = -xx; oz = DEG90;
				end else begin
					ox = -yy; oy = xx; oz = -DEG90;
				end
			end
			return {ox, oy, oz};
		end
	endfunction

	logic pole_any;
	assign pole_any = pn | ps;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else if (en) out_vld <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pole_n <= pn;
			pole_s <= ps;
			s_sq   <= s;
			if (pole_any) {vh.x, vh.y, zh} <= prerot(py, px);
			else {vh.x, vh.y, zh} <= prerot(hy, hx);
			{vb.x, vb.y, zb} <= prerot(by, bx);
			va.y <= s;
			va.x <= '0;
			za   <= '0;
		end
	end
endmodule

FILE: rtl/qte_sqrt_cell.sv
// one step of a restoring integer square root, two radicand bits per step
// depends on nothing
module qte_sqrt_cell #(
	parameter int RW = 58,
	parameter int SHIFT = 56
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] n_i,
	input  logic [RW-1:0] r_i,
	output logic [RW-1:0] n_o,
	output logic [RW-1:0] r_o
);
	logic [RW-1:0] bitv, t;
	assign bitv = RW'(1) << SHIFT;
	assign t = r_i + bitv;
	always_ff @(posedge clk) begin
		if (en) begin
			if (n_i >= t) begin
				n_o <= n_i - t;
				r_o <= (r_i >> 1) + bitv;
			end else begin
				n_o <= n_i;
				r_o <= r_i >> 1;
			end
		end
	end
endmodule

FILE: rtl/qte_cordic_cell.sv
// one vectoring cordic micro-rotation for three angle lanes
// depends on qte_pkg
module qte_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  qte_pkg::vec_t        vh_i,
	input  qte_pkg::vec_t        va_i,
	input  qte_pkg::vec_t        vb_i,
	input  qte_pkg::side_t       sd_i,
	output qte_pkg::vec_t        vh_o,
	output qte_pkg::vec_t        va_o,
	output qte_pkg::vec_t        vb_o,
	output qte_pkg::side_t       sd_o
);
	import qte_pkg::*;

	localparam logic signed [ANG_W-1:0] ANG = atan_lut(5'(STEP));

	function automatic logic [2*VEC_W+ANG_W-1:0] rot(input vec_t v,
		input logic signed [ANG_W-1:0] z);
		logic signed [VEC_W-1:0] dx, dy;
		begin
			dx = v.y >>> STEP;
			dy = v.x >>> STEP;
			if (v.y > 0) return {v.x + dx, v.y - dy, z + ANG};
			return {v.x - dx, v.y + dy, z - ANG};
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			{vh_o, sd_o.acc_h} <= rot(vh_i, sd_i.acc_h);
			{va_o, sd_o.acc_a} <= rot(va_i, sd_i.acc_a);
			{vb_o, sd_o.acc_b} <= rot(vb_i, sd_i.acc_b);
			sd_o.pole_n <= sd_i.pole_n;
			sd_o.pole_s <= sd_i.pole_s;
		end
	end
endmodule

FILE: rtl/quaternion_to_euler_angles_unit.sv
// quaternion to euler angles: 2 front stages, 29 sqrt cells, N cordic cells, 1 output stage
// one beat accepted per cycle unless the pipe is stalled
// the whole pipe advances together and stalls only when the output register is full and unread
// arst_n clears all valid flags and returns pole_threshold to 8176
// depends on qte_pkg, qte_if, qte_front, qte_sqrt_cell, qte_cordic_cell
module quaternion_to_euler_angles_unit #(
	parameter int COMPONENT_BITS   = 16,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	qte_if.sink                          quat,
	qte_if.source                        euler,
	input  logic                         cfg_we,
	input  logic [qte_pkg::THR_W-1:0]    cfg_wdata
);
	import qte_pkg::*;

	localparam int NIT   = (ANGLE_ITERATIONS < TAB_LEN) ? ANGLE_ITERATIONS : TAB_LEN;
	localparam int SQN   = 29;      // two radicand bits per sqrt cell, 58-bit radicand
	localparam int RW    = 58;

	// config register
	logic [THR_W-1:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THR_RESET;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	// global advance: pipe moves unless the output register holds an untaken beat
	logic en;
	assign en = !euler.valid || euler.ready;
	assign quat.ready = en;

	logic               f_vld;
	vec_t               f_vh, f_va, f_vb;
	logic               f_pn, f_ps;
	logic signed [ANG_W-1:0] f_zh, f_za, f_zb;
	logic signed [VEC_W-1:0] f_s;

	qte_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(quat.valid && quat.ready),
		.w_i(COMPONENT_BITS'(quat.data[4*COMPONENT_BITS-1 -: COMPONENT_BITS])),
		.x_i(COMPONENT_BITS'(quat.data[3*COMPONENT_BITS-1 -: COMPONENT_BITS])),
		.y_i(COMPONENT_BITS'(quat.data[2*COMPONENT_BITS-1 -: COMPONENT_BITS])),
		.z_i(COMPONENT_BITS'(quat.data[COMPONENT_BITS-1 -: COMPONENT_BITS])),
		.thr(thr_q), .out_vld(f_vld),
		.vh(f_vh), .va(f_va), .vb(f_vb), .pole_n(f_pn), .pole_s(f_ps),
		.zh(f_zh), .za(f_za), .zb(f_zb), .s_sq(f_s)
	);

	// valid chain from the front to the output stage
	logic [SQN+NIT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[SQN+NIT-2:0], f_vld};
	end

	// sqrt chain: c = isqrt(2^56 - s^2); heading, bank and pole data ride alongside in delay taps
	logic [RW-1:0] sq_n [SQN+1];
	logic [RW-1:0] sq_r [SQN+1];
	// s is clamped to plus or minus one in q28, so 30 bits hold it
	logic signed [29:0] s_n;
	logic signed [59:0] s2;
	assign s_n = f_s[29:0];
	assign s2 = s_n * s_n;
	assign sq_n[0] = (RW'(1) << 56) - RW'(s2);
	assign sq_r[0] = '0;

	vec_t               dl_vh [SQN+1];
	vec_t               dl_vb [SQN+1];
	logic signed [VEC_W-1:0] dl_s [SQN+1];
	side_t              dl_sd [SQN+1];
	assign dl_vh[0] = f_vh;
	assign dl_vb[0] = f_vb;
	assign dl_s[0]  = f_va.y;
	assign dl_sd[0] = '{pole_n: f_pn, pole_s: f_ps, acc_h: f_zh, acc_a: f_za, acc_b: f_zb};

	for (genvar g = 0; g < SQN; g++) begin : g_sq
		qte_sqrt_cell #(.RW(RW), .SHIFT(56 - 2*g)) u_cell (
			.clk(clk), .en(en), .n_i(sq_n[g]), .r_i(sq_r[g]),
			.n_o(sq_n[g+1]), .r_o(sq_r[g+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				dl_vh[g+1] <= dl_vh[g];
				dl_vb[g+1] <= dl_vb[g];
				dl_s[g+1]  <= dl_s[g];
				dl_sd[g+1] <= dl_sd[g];
			end
		end
	end

	// cordic chain
	vec_t  c_vh [NIT+1];
	vec_t  c_va [NIT+1];
	vec_t  c_vb [NIT+1];
	side_t c_sd [NIT+1];
	assign c_vh[0] = dl_vh[SQN];
	assign c_vb[0] = dl_vb[SQN];
	assign c_va[0] = '{x: VEC_W'(sq_r[SQN]), y: dl_s[SQN]};
	assign c_sd[0] = dl_sd[SQN];

	for (genvar g = 0; g < NIT; g++) begin : g_cr
		qte_cordic_cell #(.STEP(g)) u_cell (
			.clk(clk), .en(en),
			.vh_i(c_vh[g]), .va_i(c_va[g]), .vb_i(c_vb[g]), .sd_i(c_sd[g]),
			.vh_o(c_vh[g+1]), .va_o(c_va[g+1]), .vb_o(c_vb[g+1]), .sd_o(c_sd[g+1])
		);
	end

	// output stage: rounding, zero-vector case, pole selection
	side_t sd_e;
	logic  hz, bz, az;
	logic signed [ANG_W-1:0] ah, ab, aa, hp;
	res_t  res;
	assign sd_e = c_sd[NIT];
	// zero vectors: only zero cases survive pre-rotation as all-zero at the tail
	assign hz = (c_vh[NIT].x == '0) && (c_vh[NIT].y == '0);
	assign bz = (c_vb[NIT].x == '0) && (c_vb[NIT].y == '0);
	assign az = (c_va[NIT].x == '0) && (c_va[NIT].y == '0);
	always_comb begin
		ah = hz ? '0 : sd_e.acc_h;
		ab = bz ? '0 : sd_e.acc_b;
		aa = az ? '0 : sd_e.acc_a;
		hp = (ah + 32'sd128) >>> 8;
		res.pole_case = POLE_NONE;
		res.bank_deg  = BANK_W'((ab + 32'sd256) >>> 9);
		res.attitude_deg = ATT_W'((aa + 32'sd256) >>> 9);
		res.heading_deg  = HEAD_W'((ah + 32'sd256) >>> 9);
		if (sd_e.pole_n) begin
			res.pole_case = POLE_NORTH;
			res.heading_deg = HEAD_W'(hp);
			res.attitude_deg = ATT_P90;
			res.bank_deg = '0;
		end else if (sd_e.pole_s) begin
			res.pole_case = POLE_SOUTH;
			res.heading_deg = HEAD_W'(-hp);
			res.attitude_deg = ATT_N90;
			res.bank_deg = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) euler.valid <= 1'b0;
		else if (en) euler.valid <= vld_q[SQN+NIT-1];
	end
	always_ff @(posedge clk) begin
		if (en) euler.data <= res;
	end

`ifndef SYNTH
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid && !euler.ready |=> euler.valid && $stable(euler.data))
		else $error("output beat changed while stalled");
	a_pole: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid |-> euler.data.pole_case != 2'd3)
		else $error("bad pole code");
	a_bank: assert property (@(posedge clk) disable iff (!arst_n)
		euler.valid && euler.data.pole_case != POLE_NONE |-> euler.data.bank_deg == '0)
		else $error("bank nonzero at pole");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!euler.valid |-> quat.ready)
		else $error("input stalled with empty output");
`endif
endmodule
